// ===== sv/iafr_pkg.sv =====
// Package for the IMU angle frame receiver.
// Holds frame constants, register indexes, the parse phase type and the control struct.
// No dependencies.
package iafr_pkg;

  localparam int unsigned DATA_BYTES = 8;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [7:0] SYNC_RESET = 8'h55;
  localparam logic [7:0] TYPE_RESET = 8'h53;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TYPE = CFG_IDX_W'(1);

  localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(DATA_BYTES);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_TYPE = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef struct packed {
    logic shift;     // data byte accepted, advance the cell chain
    logic at_check;  // next accepted byte is the checksum
    logic emit;      // checksum byte accepted and matches
  } iafr_ctrl_t;

endpackage

// ===== sv/iafr_byte_cell.sv =====
// One byte cell of the payload chain.
// Depends on nothing; loads its neighbor's byte when the chain shifts.
module iafr_byte_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] d_in,
  output logic [7:0] d_out
);

  logic [7:0] data;

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= d_in;
    end
  end

  assign d_out = data;

endmodule

// ===== sv/iafr_ctrl.sv =====
// Frame parser control: header hunt, data byte count and running checksum.
// Depends on iafr_pkg.
module iafr_ctrl
  import iafr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  logic [7:0] sync_byte,
  input  logic [7:0] type_byte,
  output iafr_ctrl_t ctrl
);

  phase_t             phase, phase_next;
  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]         running_sum, running_sum_next;
  logic               full;

  assign full = (byte_count == COUNT_FULL);

  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    if (accept) begin
      unique case (phase)
        PH_TYPE: begin
          if (rx_byte == type_byte) begin
            running_sum_next = running_sum + rx_byte;
            byte_count_next  = '0;
            phase_next       = PH_DATA;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_DATA: begin
          if (!full) begin
            running_sum_next = running_sum + rx_byte;
            byte_count_next  = byte_count + COUNT_W'(1);
          end else begin
            byte_count_next = '0;
            phase_next      = PH_HUNT;
          end
        end
        default: begin
          phase_next = PH_HUNT;
          if (rx_byte == sync_byte) begin
            running_sum_next = rx_byte;
            phase_next       = PH_TYPE;
          end
        end
      endcase
    end
  end

  always_comb begin
    ctrl = '0;
    unique case (phase)
      PH_DATA: begin
        ctrl.at_check = full;
        ctrl.shift    = accept && !full;
        ctrl.emit     = accept && full && (rx_byte == running_sum);
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      byte_count  <= '0;
      running_sum <= '0;
    end else begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
    end
  end

endmodule

// ===== sv/imu_angle_frame_receiver.sv =====
// Top level of the IMU angle frame receiver.
// Depends on iafr_pkg, iafr_ctrl and iafr_byte_cell.
//
// Channel   Direction  Handshake            Payload
// in        receive    in_valid / in_stall  rx_byte
// out       send       out_valid / out_stall roll_raw, pitch_raw, yaw_raw, version_raw
// cfg       receive    cfg_valid / cfg_ready cfg_index, cfg_data
//
// One request is taken per cycle while the input is not stalled; a good frame shows
// its result on the cycle after its checksum byte. The output register holds a result
// while the next frame's bytes keep arriving; only a checksum byte is held off while an
// earlier result is still stalled.
// rst is synchronous: the parser returns to hunting, the sum and count clear, the
// registers take 0x55 and 0x53. The payload cells need no reset.
module imu_angle_frame_receiver
  import iafr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // byte input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           rx_byte,
  // result output
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          roll_raw,
  output logic [15:0]          pitch_raw,
  output logic [15:0]          yaw_raw,
  output logic [15:0]          version_raw,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic [7:0] sync_byte;
  logic [7:0] type_byte;
  logic       accept;
  iafr_ctrl_t ctrl;
  logic       out_busy;

  // Write any register at any time; unknown indexes drop.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte <= SYNC_RESET;
      type_byte <= TYPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SYNC: sync_byte <= cfg_data;
        REG_TYPE: type_byte <= cfg_data;
        default:  ;
      endcase
    end
  end

  // Hold only a checksum byte while the output register cannot drain.
  assign out_busy = out_valid && out_stall;
  assign in_stall = out_busy && ctrl.at_check;
  assign accept   = in_valid && !in_stall;

  iafr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .sync_byte (sync_byte),
    .type_byte (type_byte),
    .ctrl      (ctrl)
  );

  // Payload chain: each data byte enters at the top cell and every cell hands its byte
  // one place down, so after eight bytes cell 0 holds D0 and cell 7 holds D7.
  logic [7:0] cell_q [DATA_BYTES];

  for (genvar i = 0; i < DATA_BYTES; i++) begin : g_cell
    logic [7:0] cell_d;
    if (i == DATA_BYTES - 1) begin : g_top
      assign cell_d = rx_byte;
    end else begin : g_mid
      assign cell_d = cell_q[i+1];
    end
    iafr_byte_cell u_cell (
      .clk   (clk),
      .shift (ctrl.shift),
      .d_in  (cell_d),
      .d_out (cell_q[i])
    );
  end

  // Output register: load on a good checksum, drop the valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      roll_raw    <= {cell_q[1], cell_q[0]};
      pitch_raw   <= {cell_q[3], cell_q[2]};
      yaw_raw     <= {cell_q[5], cell_q[4]};
      version_raw <= {cell_q[7], cell_q[6]};
    end
  end

  // A new result never lands on one that is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |-> !out_busy)
    else $error("result emitted over a stalled result");

  // The input is held off only for a result that waits.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_busy)
    else $error("input stalled without a pending result");

  // A checksum byte never shifts the payload chain.
  a_emit_no_shift: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |-> !ctrl.shift)
    else $error("payload shifted on a checksum byte");

  // An emitted result is presented on the next cycle.
  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |=> out_valid)
    else $error("emitted result not presented");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for imu_angle_frame_receiver: byte driver, result monitor, predictor.
// Depends on iafr_pkg and the imu_angle_frame_receiver RTL; needs nothing else to run.
`timescale 1ns / 1ps

module testbench;
  import iafr_pkg::*;

  localparam int unsigned PHASE_COUNT   = 6;
  localparam int unsigned PHASE_ITEMS   = 330;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned PRINT_CAP     = 40;

  // Indexes past the two real registers; the block must ignore writes to them.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

  typedef struct packed {
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [15:0] yaw;
    logic [15:0] version;
  } angle_words_t;

  // Clock, reset and block ports; every input starts at a known value.
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           rx_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [15:0]          roll_raw;
  logic [15:0]          pitch_raw;
  logic [15:0]          yaw_raw;
  logic [15:0]          version_raw;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  // Requests waiting for the driver, and angle frames waiting for the monitor.
  logic [7:0]   rx_queue[$];
  angle_words_t pending_angles[$];

  // Frame parser mirror; the register copies start at their reset values.
  logic [7:0] cur_sync = SYNC_RESET;
  logic [7:0] cur_type = TYPE_RESET;
  phase_t     rx_phase = PH_HUNT;
  logic [3:0] data_count = '0;
  logic [7:0] frame_data[DATA_BYTES];
  logic [7:0] frame_sum = '0;

  int unsigned bytes_queued   = 0;
  int unsigned bytes_accepted = 0;
  int unsigned frames_checked = 0;
  int unsigned cfg_writes     = 0;
  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;
  int unsigned burst_left     = 1;
  int unsigned gap_left       = 0;
  int unsigned stall_tick     = 0;
  int unsigned stall_mode     = 0;

  imu_angle_frame_receiver i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .roll_raw    (roll_raw),
    .pitch_raw   (pitch_raw),
    .yaw_raw     (yaw_raw),
    .version_raw (version_raw),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #10 clk = ~clk;

  // Hard stop: no correct run comes anywhere near this many cycles.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d frames still pending", cycle_count,
               pending_angles.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Print one line per mismatch (up to a cap) and count it.
  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    fail_count++;
    if (fail_count <= PRINT_CAP)
      $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  // Advance the parser mirror by one accepted byte; push an angle frame when a
  // checksum byte matches the running sum.
  task automatic predict_rx(input logic [7:0] b);
    angle_words_t words;
    case (rx_phase)
      PH_TYPE: begin
        // A wrong type byte drops back to hunting and is not retried as sync.
        if (b == cur_type) begin
          frame_sum  = frame_sum + b;
          data_count = '0;
          rx_phase   = PH_DATA;
        end else begin
          rx_phase = PH_HUNT;
        end
      end
      PH_DATA: begin
        if (data_count < COUNT_FULL) begin
          // A sync value in the payload is plain data here: no resync.
          frame_data[data_count[2:0]] = b;
          frame_sum  = frame_sum + b;
          data_count = data_count + 4'd1;
        end else begin
          rx_phase   = PH_HUNT;
          data_count = '0;
          // Bad checksum: drop the frame without a result.
          if (b == frame_sum) begin
            words.roll    = {frame_data[1], frame_data[0]};
            words.pitch   = {frame_data[3], frame_data[2]};
            words.yaw     = {frame_data[5], frame_data[4]};
            words.version = {frame_data[7], frame_data[6]};
            pending_angles.push_back(words);
          end
        end
      end
      default: begin
        rx_phase = PH_HUNT;
        if (b == cur_sync) begin
          frame_sum = b;
          rx_phase  = PH_TYPE;
        end
      end
    endcase
  endtask

  // Byte driver: bursts of random length separated by random gaps. A stalled
  // request holds its byte until the block takes it.
  always @(posedge clk) begin : byte_driver
    logic       next_valid;
    logic [7:0] next_byte;
    next_valid = in_valid;
    next_byte  = rx_byte;
    if (rst) begin
      next_valid = 1'b0;
      rx_phase   = PH_HUNT;
      data_count = '0;
      frame_sum  = '0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_rx(rx_byte);
        bytes_accepted++;
      end
      if (!in_valid || !in_stall) begin
        next_valid = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (rx_queue.size() != 0) begin
          next_valid = 1'b1;
          next_byte  = rx_queue.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // Mostly short bursts, now and then a long unbroken stretch.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
    in_valid <= next_valid;
    rx_byte  <= next_byte;
  end

  // Result monitor: compare each accepted frame with the oldest prediction and
  // drive the output stall from a pattern that changes at random.
  always @(posedge clk) begin : result_monitor
    logic         next_stall;
    angle_words_t want;
    next_stall = 1'b0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_angles.size() == 0) begin
          flag_mismatch("result with nothing pending", roll_raw, '0);
        end else begin
          want = pending_angles.pop_front();
          if (roll_raw !== want.roll) flag_mismatch("roll_raw", roll_raw, want.roll);
          if (pitch_raw !== want.pitch) flag_mismatch("pitch_raw", pitch_raw, want.pitch);
          if (yaw_raw !== want.yaw) flag_mismatch("yaw_raw", yaw_raw, want.yaw);
          if (version_raw !== want.version)
            flag_mismatch("version_raw", version_raw, want.version);
          frames_checked++;
        end
      end
      stall_tick = (stall_tick + 1) % 64;
      if (stall_tick == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       next_stall = 1'b0;
        1:       next_stall = ($urandom_range(0, 3) == 0);
        2:       next_stall = ($urandom_range(0, 3) != 0);
        // Long hold: long enough for the next checksum byte to be held off.
        default: next_stall = (stall_tick < 40);
      endcase
    end
    out_stall <= next_stall;
  end

  task automatic queue_byte(input logic [7:0] b);
    rx_queue.push_back(b);
    bytes_queued++;
  endtask

  // Payload byte, biased toward the sync value to exercise no-resync.
  function automatic logic [7:0] random_data_byte();
    return ($urandom_range(0, 7) == 0) ? cur_sync : 8'($urandom_range(0, 255));
  endfunction

  // Queue a full frame under the current registers; corrupt flips checksum bits.
  task automatic queue_frame(input logic [63:0] payload, input bit corrupt);
    logic [7:0] sum;
    int         i;
    sum = cur_sync + cur_type;
    queue_byte(cur_sync);
    queue_byte(cur_type);
    for (i = 0; i < DATA_BYTES; i++) begin
      queue_byte(payload[8*i +: 8]);
      sum = sum + payload[8*i +: 8];
    end
    if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
    queue_byte(sum);
  endtask

  // Close a frame left open by the previous phase. Its header is already in
  // the running sum, so the checksum builds on the parser's sum.
  task automatic close_open_frame();
    logic [7:0] sum;
    logic [7:0] b;
    int         i;
    if (rx_phase == PH_DATA) begin
      sum = frame_sum;
      for (i = data_count; i < DATA_BYTES; i++) begin
        b = random_data_byte();
        queue_byte(b);
        sum = sum + b;
      end
      if ($urandom_range(0, 3) == 0) sum = sum ^ 8'($urandom_range(1, 255));
      queue_byte(sum);
    end
  endtask

  // Write one register; the caller lowers cfg_valid after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_SYNC) cur_sync = value;
    else if (idx == REG_TYPE) cur_type = value;
    cfg_writes++;
  endtask

  // Wait until every queued byte is taken and every frame has come out, then
  // let the parser settle.
  task automatic wait_quiet();
    do @(posedge clk);
    while (bytes_accepted != bytes_queued || pending_angles.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned ph;
    int unsigned items;
    int unsigned kind;
    int unsigned i;
    logic [63:0] payload;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (ph = 0; ph < PHASE_COUNT; ph++) begin
      // Hold off register writes until the block has drained.
      if (ph != 0) begin
        wait_quiet();
        case (ph)
          1: begin
            write_reg(REG_SYNC, 8'h00);
            write_reg(REG_TYPE, 8'hFF);
            write_reg(REG_SPARE_LO, 8'($urandom_range(0, 255)));
          end
          2: begin
            write_reg(REG_SYNC, 8'hFF);
            write_reg(REG_TYPE, 8'h00);
          end
          3: begin
            // Same value in both header positions.
            write_reg(REG_SYNC, 8'hA5);
            write_reg(REG_TYPE, 8'hA5);
          end
          default: begin
            write_reg(REG_SYNC, 8'($urandom_range(0, 255)));
            write_reg(REG_TYPE, 8'($urandom_range(0, 255)));
            write_reg(REG_SPARE_HI, 8'($urandom_range(0, 255)));
          end
        endcase
        cfg_valid <= 1'b0;
        close_open_frame();
      end else begin
        // Directed opening on reset registers: a frame with a bad checksum,
        // a wrong type byte followed by the type value (must not restart a
        // frame), then a good frame with extreme and sync-valued data.
        queue_frame(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        queue_byte(SYNC_RESET);
        queue_byte(SYNC_RESET);
        queue_byte(TYPE_RESET);
        queue_frame(64'h00FF_7F01_8055_FF00, 1'b0);
      end

      // Random part: mostly well-formed frames, some broken headers and
      // truncated frames, plus random noise bytes.
      items = 0;
      while (items < PHASE_ITEMS) begin
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
          for (i = 0; i < DATA_BYTES; i++) payload[8*i +: 8] = random_data_byte();
          queue_frame(payload, $urandom_range(0, 6) == 0);
          items += 11;
        end else if (kind < 80) begin
          queue_byte(cur_sync);
          queue_byte(cur_type ^ 8'($urandom_range(1, 255)));
          items += 2;
          if ($urandom_range(0, 1) == 1) begin
            queue_byte(cur_type);
            items++;
          end
        end else if (kind < 90) begin
          queue_byte(cur_sync);
          queue_byte(cur_type);
          items += 2;
          repeat ($urandom_range(0, 7)) begin
            queue_byte(random_data_byte());
            items++;
          end
        end else begin
          repeat ($urandom_range(1, 6)) queue_byte(8'($urandom_range(0, 255)));
        end
      end

      // Leave a frame open so the next register writes land mid-frame.
      queue_byte(cur_sync);
      if ($urandom_range(0, 1) == 1) begin
        queue_byte(cur_type);
        repeat ($urandom_range(0, 7)) queue_byte(random_data_byte());
      end
    end

    wait_quiet();
    if (pending_angles.size() != 0)
      flag_mismatch("frames never emitted", 16'(pending_angles.size()), '0);
    $display("Covered %0d bytes across %0d register settings with %0d register writes",
             bytes_accepted, PHASE_COUNT, cfg_writes);
    $display("Compared %0d angle frames, %0d mismatches", frames_checked, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/iafr_pkg.sv
sv/iafr_byte_cell.sv
sv/iafr_ctrl.sv
sv/imu_angle_frame_receiver.sv
tb/testbench.sv
